// ----- design/max_priority_queue_with_min_top_defines.svh -----
//------------------------------------------------------------------------------
// Assertion macros for the max priority queue
// Both macros sample on clk_i and are disabled while rst_ni is low.
//------------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_WITH_MIN_TOP_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_WITH_MIN_TOP_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define MPQM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define MPQM_ASSERT_NEVER(label, expr, msg) \
  `MPQM_ASSERT(label, !(expr), msg)

`endif

// ----- design/mpqm_pkg.sv -----
//------------------------------------------------------------------------------
// mpqm_pkg
// Shared types and constants of the max priority queue.
//------------------------------------------------------------------------------
package mpqm_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_PEEK   = 3'd2,
    OP_MIN    = 3'd3,
    OP_SIZE   = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ----- design/mpqm_if.sv -----
//------------------------------------------------------------------------------
// mpqm_in_if / mpqm_out_if
// Valid/ready channels for the queue commands and the queue results.
//------------------------------------------------------------------------------
interface mpqm_in_if import mpqm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           op;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface mpqm_out_if import mpqm_pkg::*; #(
  parameter int unsigned CountW = 7
);
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] result_value;
  logic [StatusW-1:0]       status;
  logic [CountW-1:0]        count;

  modport source (output valid, output result_value, output status, output count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input count,
                  output ready);
endinterface

// ----- design/mpqm_cell.sv -----
//------------------------------------------------------------------------------
// mpqm_cell
// One slot of the sorted chain: compares against the new value and shifts.
//------------------------------------------------------------------------------
module mpqm_cell import mpqm_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [ValueW-1:0] ins_val_i,
  input  logic                     occ_i,
  input  logic                     left_ge_i,
  input  logic signed [ValueW-1:0] left_val_i,
  input  logic signed [ValueW-1:0] right_val_i,
  output logic                     ge_o,
  output logic signed [ValueW-1:0] val_o
);

  logic signed [ValueW-1:0] val_q, val_d;

  // An occupied slot that holds a value not below the new one stays put.
  assign ge_o  = occ_i && (val_q >= ins_val_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.insert) begin
      if (!ge_o) begin
        val_d = left_ge_i ? ins_val_i : left_val_i;
      end
    end else if (ctrl_i.remove) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ----- design/max_priority_queue_with_min_top.sv -----
// The result of a command is registered by the edge that takes the command.
// One command per cycle while the result side takes each result; every
// cell of the chain compares and shifts in parallel for each command.
// Reset clears the element count, the result valid flag and nothing else; the
// cell contents are meaningless until written and are never read beyond count.
//------------------------------------------------------------------------------
// max_priority_queue_with_min_top
// Bounded max priority queue built as a sorted chain of compare/shift cells.
//------------------------------------------------------------------------------
`include "max_priority_queue_with_min_top_defines.svh"

module max_priority_queue_with_min_top import mpqm_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mpqm_in_if.sink           in_i,
  mpqm_out_if.source        res_o
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  // The chain keeps the elements sorted from largest to smallest, so the
  // maximum always sits in cell zero. The minimum is tracked in its own
  // register: an insert can only lower it, and removing the maximum only
  // changes it when the last element leaves.
  logic [CountW-1:0]        count_q, count_d;
  logic signed [ValueW-1:0] min_q, min_d;

  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_value_q, out_value_d;
  status_e                  out_status_q, out_status_d;
  logic [CountW-1:0]        out_count_q;

  logic                     accept;
  op_e                      op;
  logic                     empty;
  logic                     full;
  cell_ctrl_t               ctrl;

  logic signed [ValueW-1:0] cell_val [CAPACITY];
  logic                     cell_ge  [CAPACITY];

  // A new command is taken whenever the result register is free or is being
  // emptied in this same cycle.
  assign in_i.ready = !out_valid_q || res_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.op);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CountW'(CAPACITY));

  // Decode of one command: what the chain does, the new count, the new
  // minimum and the result that goes into the output register.
  always_comb begin
    ctrl         = '0;
    count_d      = count_q;
    min_d        = min_q;
    out_value_d  = '0;
    out_status_d = ST_OK;
    case (op)
      OP_INSERT: begin
        if (full) begin
          out_status_d = ST_FULL;
        end else begin
          ctrl.insert = accept;
          count_d     = count_q + CountW'(1);
          if (empty || (in_i.value < min_q)) begin
            min_d = in_i.value;
          end
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          out_status_d = ST_EMPTY;
        end else begin
          ctrl.remove = accept;
          count_d     = count_q - CountW'(1);
          out_value_d = cell_val[0];
        end
      end
      OP_PEEK: begin
        if (empty) begin
          out_status_d = ST_EMPTY;
        end else begin
          out_value_d = cell_val[0];
        end
      end
      OP_MIN: begin
        if (empty) begin
          out_status_d = ST_EMPTY;
        end else begin
          out_value_d = min_q;
        end
      end
      default: begin
        // Size report and unknown codes leave the queue as it is.
      end
    endcase
  end

  // The cell chain. Each cell sees its left neighbor's compare result and
  // value for an insert, and its right neighbor's value for a removal.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_ge;
    logic signed [ValueW-1:0] left_val;
    logic signed [ValueW-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_ge  = 1'b1;
      assign left_val = in_i.value;
    end else begin : g_body
      assign left_ge  = cell_ge[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    mpqm_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .ins_val_i   (in_i.value),
      .occ_i       (CountW'(i) < count_q),
      .left_ge_i   (left_ge),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .ge_o        (cell_ge[i]),
      .val_o       (cell_val[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; the valid flag qualifies them.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_q        <= min_d;
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_count_q  <= count_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.result_value = out_value_q;
  assign res_o.status       = out_status_q;
  assign res_o.count        = out_count_q;

  // The count never exceeds the capacity.
  `MPQM_ASSERT_NEVER(a_count_bound, count_q > CountW'(CAPACITY), "count above capacity")
  // A full report is only given when the queue really is full.
  `MPQM_ASSERT(a_full_status, (out_valid_q && (out_status_q == ST_FULL)) |-> (out_count_q == CountW'(CAPACITY)), "full status with room left")
  // Removing from a non-empty queue takes exactly one element away.
  `MPQM_ASSERT(a_remove_count, (accept && (op == OP_REMOVE) && !empty) |=> (count_q == $past(count_q) - CountW'(1)), "remove did not drop count")
  // The tracked minimum never lies above the maximum in the head cell.
  `MPQM_ASSERT(a_min_le_max, !empty |-> (min_q <= cell_val[0]), "minimum above maximum")

endmodule

// ----- dv/max_priority_queue_with_min_top_tb.sv -----
//------------------------------------------------------------------------------
// max_priority_queue_with_min_top_tb
// Self-checking bench for the bounded max priority queue. Commands are queued
// up front, sent with random gaps and accepted in order. A sorted copy of the
// queue contents predicts each result, and every result transfer is compared
// field by field with the oldest prediction.
//------------------------------------------------------------------------------
module max_priority_queue_with_min_top_tb;
  import mpqm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned CountW    = 7;
  localparam int unsigned RandCmds  = 1450;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 8;
  // Op codes above the last defined one must be ignored by the block.
  localparam int unsigned OpFirstUnused = int'(OP_SIZE) + 1;
  localparam int unsigned OpLastCode    = (1 << OpW) - 1;
  localparam logic signed [ValueW-1:0] ValMax = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic signed [ValueW-1:0] ValMin = {1'b1, {(ValueW-1){1'b0}}};

  typedef struct packed {
    logic [OpW-1:0]           op;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [ValueW-1:0] result_value;
    status_e                  status;
    logic [CountW-1:0]        count;
  } queue_result_t;

  logic clk_i;
  logic rst_ni;

  mpqm_in_if                    cmd_ch ();
  mpqm_out_if #(.CountW(CountW)) res_ch ();

  max_priority_queue_with_min_top #(
    .CAPACITY (Capacity)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch.sink),
    .res_o  (res_ch.source)
  );

  // Commands waiting to be sent, predicted results waiting to arrive, and the
  // bench's own copy of the queue, kept sorted from largest to smallest.
  cmd_t                     pending_cmds[$];
  queue_result_t            expected_results[$];
  logic signed [ValueW-1:0] held_values[$];
  cmd_t                     cmd_on_bus;
  int unsigned              total_cmds;
  int unsigned              accepted_cmds;
  int unsigned              mismatches;
  int unsigned              stall_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Works out the result of one command and updates the sorted copy. A new
  // value goes behind any equal ones; only values are visible, so the order
  // among equals cannot be told apart anyway.
  function automatic queue_result_t apply_command(cmd_t cmd);
    queue_result_t res;
    int unsigned   pos;
    res.result_value = '0;
    res.status       = ST_OK;
    case (cmd.op)
      OP_INSERT: begin
        if (held_values.size() >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_values.size() && held_values[pos] >= cmd.value) pos++;
          held_values.insert(pos, cmd.value);
        end
      end
      OP_REMOVE: begin
        if (held_values.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.result_value = held_values.pop_front();
        end
      end
      OP_PEEK: begin
        if (held_values.size() == 0) res.status = ST_EMPTY;
        else res.result_value = held_values[0];
      end
      OP_MIN: begin
        if (held_values.size() == 0) res.status = ST_EMPTY;
        else res.result_value = held_values[held_values.size()-1];
      end
      default: begin
        // Size report and unused codes leave everything unchanged.
      end
    endcase
    res.count = CountW'(held_values.size());
    return res;
  endfunction

  // Idling schedule: the receiver is slow first, then the sender, then both
  // sides run flat out for the last third of the commands.
  function automatic int unsigned send_idle_pct();
    if (accepted_cmds < total_cmds / 3) return 30;
    if (accepted_cmds < 2 * total_cmds / 3) return 86;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (accepted_cmds < total_cmds / 3) return 86;
    if (accepted_cmds < 2 * total_cmds / 3) return 30;
    return 0;
  endfunction

  // Values are full-range half the time, a narrow band around zero otherwise so that
  // duplicates are common, with values at or near the two extremes mixed in.
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? ValMax : ValMin;
      1: return $urandom_range(1) ? ValMax - $urandom_range(3) : ValMin + $urandom_range(3);
      2, 3, 4: return ValueW'(int'($urandom_range(16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic [OpW-1:0] op, logic signed [ValueW-1:0] value);
    cmd_t cmd;
    cmd.op    = op;
    cmd.value = value;
    return cmd;
  endfunction

  // Random traffic in blocks that lean toward filling, churning or draining the
  // queue in turn, so that both the full and the empty queue are hit many times.
  task automatic add_random_cmds(int unsigned n);
    int unsigned insert_pct;
    int unsigned block_left;
    int unsigned lean;
    int unsigned pick;
    logic [OpW-1:0] op;
    lean       = 0;
    block_left = 0;
    insert_pct = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (block_left == 0) begin
        case (lean % 3)
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
        lean++;
        block_left = $urandom_range(140, 60);
      end
      block_left--;
      if ($urandom_range(99) < insert_pct) begin
        op = OP_INSERT;
      end else begin
        pick = $urandom_range(99);
        if (pick < 55) op = OP_REMOVE;
        else if (pick < 70) op = OP_PEEK;
        else if (pick < 85) op = OP_MIN;
        else if (pick < 95) op = OP_SIZE;
        else op = OpW'($urandom_range(OpLastCode, OpFirstUnused));
      end
      pending_cmds.push_back(make_cmd(op, pick_value()));
    end
  endtask

  // Command driver. A prediction is made at the edge where a transfer takes
  // place, so it follows the acceptance order exactly. valid is assigned once
  // per edge, so a command that follows straight on keeps it high.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_results.push_back(apply_command(cmd_on_bus));
        accepted_cmds++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          cmd_on_bus = pending_cmds.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.op    <= cmd_on_bus.op;
          cmd_ch.value <= cmd_on_bus.value;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding: value %0d status %0d count %0d",
                 res_ch.result_value, res_ch.status, res_ch.count);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.result_value !== want.result_value) begin
            $error("result_value: expected %0d, actual %0d", want.result_value,
                   res_ch.result_value);
            mismatches++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_ch.status);
            mismatches++;
          end
          if (res_ch.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, res_ch.count);
            mismatches++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // Watchdog: the run is stuck if neither channel completes a transfer for a
  // long stretch. The limit is far above the longest plausible receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.op     = OP_SIZE;
    cmd_ch.value  = '0;
    res_ch.ready  = 1'b0;
    accepted_cmds = 0;
    mismatches    = 0;
    stall_cycles  = 0;
    cmd_on_bus    = '0;

    // Directed opening: every query on an empty queue, the unused op codes,
    // both value extremes, equal values, and a drain back to empty.
    pending_cmds.push_back(make_cmd(OP_REMOVE, ValMax));
    pending_cmds.push_back(make_cmd(OP_PEEK, '0));
    pending_cmds.push_back(make_cmd(OP_MIN, ValMin));
    pending_cmds.push_back(make_cmd(OP_SIZE, '1));
    for (int unsigned c = OpFirstUnused; c <= OpLastCode; c++) begin
      pending_cmds.push_back(make_cmd(OpW'(c), $urandom));
    end
    pending_cmds.push_back(make_cmd(OP_INSERT, ValMax));
    pending_cmds.push_back(make_cmd(OP_INSERT, ValMin));
    pending_cmds.push_back(make_cmd(OP_INSERT, '0));
    pending_cmds.push_back(make_cmd(OP_INSERT, '1));
    pending_cmds.push_back(make_cmd(OP_INSERT, '0));
    pending_cmds.push_back(make_cmd(OP_PEEK, '0));
    pending_cmds.push_back(make_cmd(OP_MIN, '0));
    pending_cmds.push_back(make_cmd(OP_SIZE, '0));
    pending_cmds.push_back(make_cmd(OpW'(OpLastCode), '0));
    for (int unsigned k = 0; k < 5; k++) begin
      pending_cmds.push_back(make_cmd(OP_REMOVE, '0));
    end
    pending_cmds.push_back(make_cmd(OP_MIN, '0));
    pending_cmds.push_back(make_cmd(OP_REMOVE, '0));

    add_random_cmds(RandCmds);
    total_cmds = pending_cmds.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cmds < total_cmds || expected_results.size() != 0) @(posedge clk_i);
    // Let any stray extra result show up before the verdict.
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
